// ===== rtl/core/jcre_pkg.sv =====
// Shared types, constants and value recovery for the JPEG coefficient run expander.
package jcre_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int BLOCK_LEN    = 64;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [7:0] SYM_EOB   = 8'h00;
  localparam logic [7:0] SYM_ZRL   = 8'hF0;
  localparam logic [6:0] ZRL_COUNT = 7'd16;
  localparam logic [5:0] LAST_POS  = 6'(BLOCK_LEN - 1);

  // Input beat
  typedef struct packed {
    logic [1:0]  channel;
    logic [7:0]  symbol;
    logic [14:0] magnitude_bits;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic signed [15:0] coefficient;
    logic [5:0]         position;
    logic [1:0]         block_channel;
    logic               last;
    logic               overrun;
  } out_beat_t;

  // Size-based sign recovery: bits with a clear top bit are negative
  function automatic logic [15:0] recover_value(input logic [3:0] size,
                                                input logic [14:0] raw);
    logic [15:0] mask;
    logic [15:0] v;
    logic [15:0] top;
    mask = (16'd1 << size) - 16'd1;
    v    = {1'b0, raw} & mask;
    top  = v >> (size - 4'd1);
    if (size == 4'd0) begin
      recover_value = 16'd0;
    end else if (top[0] == 1'b0) begin
      recover_value = v - mask;
    end else begin
      recover_value = v;
    end
  endfunction

endpackage

// ===== rtl/core/jpeg_coefficient_run_expander.sv =====
// JPEG baseline coefficient run expander: symbols in, zigzag coefficients out.
// A symbol is taken in the idle cycle and decoded in the next, then its coefficients leave one
// per cycle from the output register while out_stall is low, the first registered in the emit state after decode.
// The input is stalled from acceptance until the symbol's last coefficient is registered, so no new
// symbol is taken before the last one is through; stall on the output prolongs the hold.
// Synchronous active-low reset: expects a DC symbol next, DC predictors and channel zero.
module jpeg_coefficient_run_expander
  import jcre_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  typedef enum logic [1:0] {S_IDLE, S_DEC, S_EMIT} state_t;

  state_t         state_r, state_nxt;
  logic [6:0]     pos_r, pos_nxt;
  logic [1:0]     chan_r, chan_nxt;
  logic [15:0]    dc_pred_r [NUM_CHANNELS];
  logic           pred_we;
  logic [15:0]    pred_wdata;
  in_beat_t       item_r;
  logic [5:0]     cur_r, cur_nxt;
  logic [5:0]     stop_r, stop_nxt;
  logic           val_en_r, val_en_nxt;
  logic [15:0]    val_r, val_nxt;
  logic           ovr_r, ovr_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_beat_t      out_data_r, out_data_nxt;

  // Decode helpers
  logic [3:0]          run;
  logic [3:0]          size;
  logic [15:0]         rec;
  logic [1:0]          ch_sat;
  logic [CH_IDX_W-1:0] ch_idx;
  logic [6:0]          target;
  logic                is_dc;
  logic                out_free;
  logic                at_stop;
  logic [6:0]          cur_inc;

  assign run     = item_r.symbol[7:4];
  assign size    = item_r.symbol[3:0];
  assign rec     = recover_value(size, item_r.magnitude_bits);
  assign ch_sat  = (int'(item_r.channel) >= NUM_CHANNELS) ? 2'(NUM_CHANNELS - 1)
                                                           : item_r.channel;
  assign ch_idx  = ch_sat[CH_IDX_W-1:0];
  assign is_dc   = (pos_r == 7'd0) || (pos_r >= 7'(BLOCK_LEN));
  assign target  = pos_r + ((item_r.symbol == SYM_ZRL) ? (ZRL_COUNT - 7'd1)
                                                       : {3'd0, run});
  assign out_free = !out_valid_r || !out_stall;
  assign at_stop  = (cur_r == stop_r);
  // shared cursor incrementer: next emit slot and next block position
  assign cur_inc  = {1'b0, cur_r} + 7'd1;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    chan_nxt      = chan_r;
    cur_nxt       = cur_r;
    stop_nxt      = stop_r;
    val_en_nxt    = val_en_r;
    val_nxt       = val_r;
    ovr_nxt       = ovr_r;
    pred_we       = 1'b0;
    pred_wdata    = dc_pred_r[ch_idx] + rec;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_EMIT;
        ovr_nxt   = 1'b0;
        if (is_dc) begin
          pred_we    = 1'b1;
          chan_nxt   = ch_sat;
          cur_nxt    = 6'd0;
          stop_nxt   = 6'd0;
          val_en_nxt = 1'b1;
          val_nxt    = pred_wdata;
        end else begin
          cur_nxt    = pos_r[5:0];
          val_nxt    = rec;
          if (item_r.symbol == SYM_EOB) begin
            stop_nxt   = LAST_POS;
            val_en_nxt = 1'b0;
          end else if (target > {1'b0, LAST_POS}) begin
            // run past the block end: zero fill, flag on the final slot
            stop_nxt   = LAST_POS;
            val_en_nxt = 1'b0;
            ovr_nxt    = 1'b1;
          end else begin
            stop_nxt   = target[5:0];
            val_en_nxt = (item_r.symbol != SYM_ZRL);
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.coefficient   = (at_stop && val_en_r) ? val_r : 16'd0;
          out_data_nxt.position      = cur_r;
          out_data_nxt.block_channel = chan_r;
          out_data_nxt.last          = (cur_r == LAST_POS);
          out_data_nxt.overrun       = at_stop && ovr_r;
          if (at_stop) begin
            state_nxt = S_IDLE;
            pos_nxt   = (cur_r == LAST_POS) ? 7'd0 : cur_inc;
          end else begin
            cur_nxt = cur_inc[5:0];
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= 7'd0;
      chan_r      <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        dc_pred_r[i] <= 16'd0;
      end
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
      if (pred_we) begin
        dc_pred_r[ch_idx] <= pred_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      item_r <= in_data;
    end
    cur_r      <= cur_nxt;
    stop_r     <= stop_nxt;
    val_en_r   <= val_en_nxt;
    val_r      <= val_nxt;
    ovr_r      <= ovr_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DEC))
    else $error("accepted beat not decoded next cycle");

  a_overrun_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.overrun) |-> out_data_r.last)
    else $error("overrun flagged off the final coefficient");

  a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (cur_r <= stop_r))
    else $error("emit cursor passed its stop position");

  a_dc_position: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEC && is_dc) |=> (cur_r == 6'd0 && stop_r == 6'd0))
    else $error("DC symbol not routed to position zero");

endmodule

// ===== bench/jcre_coef_checker.sv =====
// Coefficient checker: predicts the expander's coefficient stream and compares every result beat.
`timescale 1ns / 100ps
module jcre_coef_checker
  import jcre_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending_count
);

  // Predictor state: block cursor, per-channel DC predictors, latched channel
  logic [6:0]  next_pos;
  logic [15:0] dc_pred [NUM_CHANNELS];
  logic [1:0]  cur_ch;
  out_beat_t   coef_expect [$];
  int          reported;

  // Sign recovery: a clear top bit marks a negative value, -(inverted bits)
  function automatic logic [15:0] magnitude_value(input logic [3:0] sz,
                                                  input logic [14:0] bits);
    logic [15:0] span;
    logic [15:0] v;
    span = (16'd1 << sz) - 16'd1;
    v    = {1'b0, bits} & span;
    if (sz == 4'd0) return 16'd0;
    if (v[sz - 4'd1]) return v;
    return -(span & ~v);
  endfunction

  function automatic void push_coef(input logic [15:0] value, input logic [5:0] pos,
                                    input logic fin, input logic ovr);
    out_beat_t r;
    r.coefficient   = value;
    r.position      = pos;
    r.block_channel = cur_ch;
    r.last          = fin;
    r.overrun       = ovr;
    coef_expect = {coef_expect, r};
  endfunction

  // Zeros from the cursor up to upto; overrun only ever rides on the final slot
  function automatic void fill_zeros(input int upto, input logic ovr);
    for (int p = int'(next_pos); p <= upto; p++)
      push_coef(16'd0, 6'(p), p == BLOCK_LEN - 1, (p == BLOCK_LEN - 1) && ovr);
  endfunction

  // Expected coefficients for one symbol beat
  function automatic void expand_symbol(input in_beat_t b);
    int         target;
    logic [1:0] ch;
    if (next_pos == 7'd0 || next_pos >= 7'(BLOCK_LEN)) begin
      // DC: run nibble ignored, channel saturated, predictor wraps at 16 bits
      ch = (int'(b.channel) > NUM_CHANNELS - 1) ? 2'(NUM_CHANNELS - 1) : b.channel;
      cur_ch = ch;
      dc_pred[ch] = dc_pred[ch] + magnitude_value(b.symbol[3:0], b.magnitude_bits);
      push_coef(dc_pred[ch], 6'd0, 1'b0, 1'b0);
      next_pos = 7'd1;
    end else if (b.symbol == SYM_EOB) begin
      fill_zeros(BLOCK_LEN - 1, 1'b0);
      next_pos = 7'd0;
    end else begin
      if (b.symbol == SYM_ZRL) begin
        target = int'(next_pos) + int'(ZRL_COUNT) - 1;
      end else begin
        target = int'(next_pos) + int'(b.symbol[7:4]);
      end
      if (target > BLOCK_LEN - 1) begin
        // run past the block end: zero fill, flag on the final slot, value dropped
        fill_zeros(BLOCK_LEN - 1, 1'b1);
        next_pos = 7'd0;
      end else begin
        if (b.symbol == SYM_ZRL) begin
          fill_zeros(target, 1'b0);
        end else begin
          fill_zeros(target - 1, 1'b0);
          push_coef(magnitude_value(b.symbol[3:0], b.magnitude_bits), 6'(target),
                    target == BLOCK_LEN - 1, 1'b0);
        end
        next_pos = (target == BLOCK_LEN - 1) ? 7'd0 : 7'(target + 1);
      end
    end
  endfunction

  // Watch both channels; inputs feed the predictor, results are compared in order
  always @(posedge clk) begin : watch
    out_beat_t want;
    logic      bad;
    if (!rst_n) begin
      next_pos = 7'd0;
      cur_ch   = 2'd0;
      foreach (dc_pred[i]) dc_pred[i] = 16'd0;
      coef_expect.delete();
      reported = 0;
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall) expand_symbol(in_data);
      if (out_valid && !out_stall) begin
        if (coef_expect.size() == 0) begin
          bad = 1'b1;
          if (reported < 10)
            $display("%0t: unexpected beat coef %0d pos %0d ch %0d last %0b ovr %0b",
                     $time, out_data.coefficient, out_data.position,
                     out_data.block_channel, out_data.last, out_data.overrun);
        end else begin
          want = coef_expect.pop_front();
          bad  = want.coefficient !== out_data.coefficient ||
                 want.position !== out_data.position ||
                 want.block_channel !== out_data.block_channel ||
                 want.last !== out_data.last ||
                 want.overrun !== out_data.overrun;
          if (bad && reported < 10)
            $display("%0t: mismatch exp coef %0d pos %0d ch %0d last %0b ovr %0b, %s",
                     $time, want.coefficient, want.position, want.block_channel,
                     want.last, want.overrun,
                     $sformatf("got coef %0d pos %0d ch %0d last %0b ovr %0b",
                               out_data.coefficient, out_data.position,
                               out_data.block_channel, out_data.last,
                               out_data.overrun));
        end
        if (bad) begin
          reported++;
          fail_count <= fail_count + 1;
        end
      end
      pending_count <= coef_expect.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Testbench top for the JPEG coefficient run expander: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench
  import jcre_pkg::*;
();

  localparam int RANDOM_ITEMS = 95;
  localparam int LONG_HOLD    = 150;
  localparam int SETTLE       = 80;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  int        fail_count;
  int        pending_count;

  int items_sent;
  int gen_pos;
  bit long_hold_req = 1'b0;
  bit tx_quiet      = 1'b0;
  bit rx_quiet      = 1'b0;

  always #6 clk = ~clk;

  jpeg_coefficient_run_expander DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  jcre_coef_checker coef_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Idle length: mostly none, often short, now and then long
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one beat until taken; track where the block cursor will be
  task automatic send_beat(input logic [1:0] ch, input logic [7:0] sym,
                           input logic [14:0] mag);
    int gap;
    int reach;
    in_data  <= in_beat_t'{channel: ch, symbol: sym, magnitude_bits: mag};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (gen_pos == 0) begin
      gen_pos = 1;
    end else if (sym == SYM_EOB) begin
      gen_pos = 0;
    end else begin
      reach   = (sym == SYM_ZRL) ? gen_pos + 15 : gen_pos + int'(sym[7:4]);
      gen_pos = (reach >= BLOCK_LEN - 1) ? 0 : reach + 1;
    end
    gap = tx_quiet ? 0 : gap_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender goes quiet until every predicted coefficient has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // Receiver: random stall stretches, plus one long hold on request
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = rx_quiet ? 0 : gap_cycles();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    int         blk;
    int         n_ac;
    int         room;
    int         r;
    int         random_start;
    logic [3:0] run;
    logic [3:0] sz;
    logic [7:0] sym;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    items_sent = 0;
    gen_pos    = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // DC of size zero with a stray run nibble, then end of block straight away
    send_beat(2'd0, 8'h50, 15'h7FFF);
    send_beat(2'd3, SYM_EOB, 15'h7FFF);
    // widest baseline DC, size-one negative, valueless run, long run at size ten
    send_beat(2'd1, 8'h0B, 15'h07FF);
    send_beat(2'd2, 8'h01, 15'h0000);
    send_beat(2'd0, 8'h30, 15'h1234);
    send_beat(2'd1, 8'hFA, 15'h0000);
    send_beat(2'd0, SYM_EOB, 15'h0000);
    // oversized DC of size fifteen; a value lands on the final slot
    send_beat(2'd2, 8'h0F, 15'h0000);
    repeat (3) send_beat(2'd1, SYM_ZRL, 15'h2AAA);
    send_beat(2'd3, 8'hEF, 15'h7FFF);
    // runs of fifteen, then a value run past the end is dropped
    send_beat(2'd3, 8'h0F, 15'h4000);
    repeat (3) send_beat(2'd0, 8'hF5, 15'h0015);
    send_beat(2'd2, 8'hFA, 15'h03FF);
    // zero run finishing exactly on the final slot
    send_beat(2'd1, 8'h05, 15'h7FE0);
    repeat (2) send_beat(2'd2, SYM_ZRL, 15'h0000);
    send_beat(2'd0, 8'hE1, 15'h0001);
    send_beat(2'd3, SYM_ZRL, 15'h5555);
    // zero run reaching past the end
    send_beat(2'd0, 8'h2C, 15'h5555);
    repeat (3) send_beat(2'd1, SYM_ZRL, 15'h0000);
    send_beat(2'd2, SYM_ZRL, 15'h7FFF);
    wait_drained();

    // Random blocks: mostly well-formed, some noise symbols that overrun
    blk = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      rx_quiet = ($urandom_range(0, 4) == 0);
      if (blk == 3) begin
        // receiver holds off while the sender keeps offering
        long_hold_req = 1'b1;
        tx_quiet      = 1'b1;
      end
      if (blk == 7) wait_drained();
      sz = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      send_beat(2'($urandom), {4'($urandom), sz}, 15'($urandom));
      n_ac = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
      while (gen_pos != 0 && n_ac > 0) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          sym = SYM_ZRL;
        end else if (r < 16) begin
          sym = 8'($urandom);
        end else begin
          room = BLOCK_LEN - 1 - gen_pos;
          run  = 4'($urandom_range(0, (room < 15) ? room : 15));
          sz   = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                              : 4'($urandom_range(1, 10));
          sym  = {run, sz};
        end
        send_beat(2'($urandom), sym, 15'($urandom));
        n_ac--;
      end
      if (gen_pos != 0) send_beat(2'($urandom), SYM_EOB, 15'($urandom));
      blk++;
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #18_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
